// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ----- rtl/core/tvem_pkg.sv -----
package tvem_pkg;

  // Field widths.
  localparam int unsigned SampleW = 10;
  localparam int unsigned SupplyW = 16;
  localparam int unsigned TubeW = 14;
  localparam int unsigned DivMvW = 12;

  // Arithmetic constants.
  localparam logic [SampleW-1:0] SampleFull = 10'd1023;
  localparam int unsigned DividendW = 24;
  localparam logic [DividendW-1:0] SupplyNumerator = 24'd1126400;
  localparam int unsigned ScaleShift = 10;
  localparam logic [12:0] TubeRatioNum = 13'd5022;
  localparam logic [TubeW-1:0] TubeMax = 14'd14940;

  // Reciprocal for the divide by 22: exact for every dividend below 2^16.
  localparam int unsigned ScaleRecipW = 16;
  localparam logic [ScaleRecipW-1:0] ScaleRecip = 16'd47663;
  localparam int unsigned ScaleRecipShift = 20;

  // Reciprocal for the divide by 1000: exact for every dividend up to 14940450.
  localparam int unsigned TubeRecipW = 24;
  localparam logic [TubeRecipW-1:0] TubeRecip = 24'd8589935;
  localparam int unsigned TubeRecipShift = 33;

  // Iterative divider: one quotient bit per cycle.
  localparam int unsigned DivSteps = DividendW;
  localparam int unsigned DivCntW = $clog2(DivSteps);

  // Request queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // One window-end request: midpoint of the window and the band-gap reading.
  typedef struct packed {
    logic [SampleW-1:0] mid;
    logic [SampleW-1:0] bandgap;
  } req_t;

  // Divider request and response.
  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [SampleW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DividendW-1:0] quotient;
  } div_rsp_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUPPLY,
    ST_SCALE,
    ST_DIV22,
    ST_TUBE,
    ST_DIV1000,
    ST_EMIT
  } back_state_t;

endpackage

// ----- rtl/core/tube_voltage_envelope_monitor.sv -----
// Flow: an accepted window-end request passes through the queue, the 24-step one-bit-per-cycle
// supply division, and five register stages for the scaling, the two reciprocal divisions and
// the output register. Throughput: requests are taken one per cycle while the queue has room;
// the back end works on one window end at a time and pops the next only once idle, so input
// stalls only while the two-entry queue is full.
// Reset: synchronous active-high rst empties the queue, idles the sequencer and
// restores the window to minimum 1023 and maximum 0.
`include "assert_macros.svh"

module tube_voltage_envelope_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tvem_pkg::SampleW-1:0]  sample,
  input  logic                          window_end,
  input  logic [tvem_pkg::SampleW-1:0]  bandgap_reading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tvem_pkg::SupplyW-1:0]  supply_mv,
  output logic [tvem_pkg::TubeW-1:0]    tube_volts
);

  logic           push;
  logic           pop;
  logic           q_valid;
  logic           q_full;
  tvem_pkg::req_t push_req;
  tvem_pkg::req_t pop_req;

  // Front end: window tracking and window-end detection.
  tvem_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .window_end      (window_end),
    .bandgap_reading (bandgap_reading),
    .q_full          (q_full),
    .push            (push),
    .push_req        (push_req)
  );

  // Queue of pending window-end requests.
  tvem_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .pop_req  (pop_req)
  );

  // Back end: supply and tube voltage arithmetic.
  tvem_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .pop_req    (pop_req),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .supply_mv  (supply_mv),
    .tube_volts (tube_volts)
  );

  // A window end is never written into a full queue.
  `ASSERT_IMPLY(a_no_push_full, clk, rst, push, !q_full, "push into full queue")
  // The back end only pops an occupied queue.
  `ASSERT_IMPLY(a_no_pop_empty, clk, rst, pop, q_valid, "pop from empty queue")
  // A delivered tube voltage stays within the reachable range.
  `ASSERT_IMPLY(a_tube_range, clk, rst, out_valid, tube_volts <= tvem_pkg::TubeMax, "tube range")

endmodule

// ----- rtl/core/tvem_front.sv -----
module tvem_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tvem_pkg::SampleW-1:0]   sample,
  input  logic                           window_end,
  input  logic [tvem_pkg::SampleW-1:0]   bandgap_reading,
  input  logic                           q_full,
  output logic                           push,
  output tvem_pkg::req_t                 push_req
);

  logic [tvem_pkg::SampleW-1:0] window_min;
  logic [tvem_pkg::SampleW-1:0] window_max;
  logic [tvem_pkg::SampleW-1:0] min_next;
  logic [tvem_pkg::SampleW-1:0] max_next;
  logic [tvem_pkg::SampleW:0]   mid_sum;
  logic                         accept;

  // The front takes requests as long as the queue has room.
  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  // Fold the sample into the window first.
  always_comb begin
    min_next = (sample < window_min) ? sample : window_min;
    max_next = (sample > window_max) ? sample : window_max;
    mid_sum = {1'b0, min_next} + {1'b0, max_next};
  end

  // A window end hands the midpoint and band-gap reading to the back end.
  assign push = accept && window_end;
  assign push_req.mid = mid_sum[tvem_pkg::SampleW:1];
  assign push_req.bandgap = bandgap_reading;

  // Window registers restart after each window end.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_min <= tvem_pkg::SampleFull;
      window_max <= '0;
    end else if (accept) begin
      if (window_end) begin
        window_min <= tvem_pkg::SampleFull;
        window_max <= '0;
      end else begin
        window_min <= min_next;
        window_max <= max_next;
      end
    end
  end

endmodule

// ----- rtl/core/tvem_queue.sv -----
module tvem_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tvem_pkg::req_t push_req,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output tvem_pkg::req_t pop_req
);

  tvem_pkg::req_t               entries [tvem_pkg::QDepth];
  logic [tvem_pkg::QPtrW-1:0]   wr_ptr;
  logic [tvem_pkg::QPtrW-1:0]   rd_ptr;
  logic [tvem_pkg::QCntW-1:0]   count;

  assign q_valid = (count != '0);
  assign q_full = (count == tvem_pkg::QCntW'(tvem_pkg::QDepth));
  assign pop_req = entries[rd_ptr];

  // Pointer wrap at the queue depth.
  function automatic logic [tvem_pkg::QPtrW-1:0] ptr_inc(input logic [tvem_pkg::QPtrW-1:0] p);
    ptr_inc = (p == tvem_pkg::QPtrW'(tvem_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/tvem_div.sv -----
module tvem_div (
  input  logic                clk,
  input  logic                rst,
  input  tvem_pkg::div_req_t  div_req,
  output tvem_pkg::div_rsp_t  div_rsp
);

  logic                            busy;
  logic                            done;
  logic [tvem_pkg::DivCntW-1:0]    cnt;
  logic [tvem_pkg::SampleW-1:0]    divisor;
  logic [tvem_pkg::SampleW-1:0]    rem;
  logic [tvem_pkg::DividendW-1:0]  quo;
  logic [tvem_pkg::SampleW:0]      shifted;
  logic [tvem_pkg::SampleW:0]      diff;
  logic                            take;

  assign div_rsp.busy = busy;
  assign div_rsp.done = done;
  assign div_rsp.quotient = quo;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem, quo[tvem_pkg::DividendW-1]};
    diff = shifted - {1'b0, divisor};
    take = (shifted >= {1'b0, divisor});
  end

  // Datapath: quo holds the remaining dividend bits above the quotient bits.
  always_ff @(posedge clk) begin
    if (div_req.start && !busy) begin
      quo <= div_req.dividend;
      rem <= '0;
      divisor <= div_req.divisor;
    end else if (busy) begin
      rem <= take ? diff[tvem_pkg::SampleW-1:0] : shifted[tvem_pkg::SampleW-1:0];
      quo <= {quo[tvem_pkg::DividendW-2:0], take};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (div_req.start && !busy) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == tvem_pkg::DivCntW'(tvem_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/tvem_back.sv -----
module tvem_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tvem_pkg::req_t                pop_req,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tvem_pkg::SupplyW-1:0]  supply_mv,
  output logic [tvem_pkg::TubeW-1:0]    tube_volts
);

  localparam int unsigned ScaleProdW = tvem_pkg::SampleW + tvem_pkg::SupplyW;
  localparam int unsigned TubeProdW = 13 + tvem_pkg::DivMvW;
  localparam int unsigned Div22ProdW = tvem_pkg::SupplyW + tvem_pkg::ScaleRecipW;
  localparam int unsigned Div1000ProdW = tvem_pkg::DividendW + tvem_pkg::TubeRecipW;

  tvem_pkg::back_state_t          state;
  tvem_pkg::back_state_t          state_next;
  tvem_pkg::div_req_t             div_req;
  tvem_pkg::div_rsp_t             div_rsp;
  logic [tvem_pkg::SampleW-1:0]   mid;
  logic [tvem_pkg::SupplyW-1:0]   supply;
  logic [tvem_pkg::SupplyW-1:0]   supply_sat;
  logic [ScaleProdW-1:0]          scale_prod;
  logic [tvem_pkg::SupplyW-1:0]   scaled;
  logic [Div22ProdW-1:0]          div22_prod;
  logic [tvem_pkg::DivMvW-1:0]    div_mv;
  logic [TubeProdW-1:0]           tube_prod;
  logic [tvem_pkg::DividendW-1:0] tube_scaled;
  logic [Div1000ProdW-1:0]        div1000_prod;
  logic [tvem_pkg::TubeW-1:0]     tube;
  logic                           emit;

  tvem_div u_div (
    .clk     (clk),
    .rst     (rst),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // Saturate the supply quotient to 16 bits; a zero divisor yields all ones.
  assign supply_sat = (div_rsp.quotient[tvem_pkg::DividendW-1:tvem_pkg::SupplyW] != '0) ?
                      '1 : div_rsp.quotient[tvem_pkg::SupplyW-1:0];

  // One multiply per stage; the divides by constants are reciprocal multiplications.
  assign scale_prod = {{tvem_pkg::SupplyW{1'b0}}, mid} * {{tvem_pkg::SampleW{1'b0}}, supply};
  assign div22_prod = {{tvem_pkg::ScaleRecipW{1'b0}}, scaled} *
                      {{tvem_pkg::SupplyW{1'b0}}, tvem_pkg::ScaleRecip};
  assign tube_prod = {{tvem_pkg::DivMvW{1'b0}}, tvem_pkg::TubeRatioNum} * {13'd0, div_mv};
  assign div1000_prod = {{tvem_pkg::TubeRecipW{1'b0}}, tube_scaled} *
                        {{tvem_pkg::DividendW{1'b0}}, tvem_pkg::TubeRecip};

  // Sequencer: supply divide, scale, divide by 22, tube scale, divide by 1000, emit.
  always_comb begin
    state_next = state;
    pop = 1'b0;
    emit = 1'b0;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = '0;
    case (state)
      tvem_pkg::ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          div_req.start = 1'b1;
          div_req.dividend = tvem_pkg::SupplyNumerator;
          div_req.divisor = pop_req.bandgap;
          state_next = tvem_pkg::ST_SUPPLY;
        end
      end
      tvem_pkg::ST_SUPPLY: begin
        if (div_rsp.done) begin
          state_next = tvem_pkg::ST_SCALE;
        end
      end
      tvem_pkg::ST_SCALE: begin
        state_next = tvem_pkg::ST_DIV22;
      end
      tvem_pkg::ST_DIV22: begin
        state_next = tvem_pkg::ST_TUBE;
      end
      tvem_pkg::ST_TUBE: begin
        state_next = tvem_pkg::ST_DIV1000;
      end
      tvem_pkg::ST_DIV1000: begin
        state_next = tvem_pkg::ST_EMIT;
      end
      tvem_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit = 1'b1;
          state_next = tvem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tvem_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers for the request in progress.
  always_ff @(posedge clk) begin
    if (pop) begin
      mid <= pop_req.mid;
    end
    if (state == tvem_pkg::ST_SUPPLY && div_rsp.done) begin
      supply <= supply_sat;
    end
    if (state == tvem_pkg::ST_SCALE) begin
      scaled <= scale_prod[ScaleProdW-1:tvem_pkg::ScaleShift];
    end
    if (state == tvem_pkg::ST_DIV22) begin
      div_mv <= div22_prod[tvem_pkg::ScaleRecipShift +: tvem_pkg::DivMvW];
    end
    if (state == tvem_pkg::ST_TUBE) begin
      tube_scaled <= tube_prod[tvem_pkg::DividendW-1:0];
    end
    if (state == tvem_pkg::ST_DIV1000) begin
      tube <= div1000_prod[tvem_pkg::TubeRecipShift +: tvem_pkg::TubeW];
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      supply_mv <= supply;
      tube_volts <= tube;
    end
  end

endmodule
